/* rtl/core/cmc_pkg.sv */
// Shared types, widths and constants of the coverage multiplicity classifier.
package cmc_pkg;

  // Field and register widths
  localparam int RATE_W   = 32;
  localparam int LEN_W    = 24;
  localparam int CNT_W    = 24;
  localparam int MULT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 32;

  // Arithmetic widths
  localparam int A_W  = RATE_W + LEN_W;     // rate times length
  localparam int AL_W = 32;                 // low part of a
  localparam int AH_W = A_W - AL_W;         // high part of a
  localparam int R_W  = 2 * CNT_W;          // count squared
  localparam int P_W  = 2 * A_W;            // a squared
  localparam int Q_W  = CNT_W + A_W;        // count times a
  localparam int SQ_W = 124;                // working width of squared scores
  localparam int FRAC_W = 24;               // rate fraction bits

  // Score thresholds: first keep |z| < 7/2, final accept |z| < 3
  localparam int KEEP_NUM  = 49;
  localparam int KEEP_DEN  = 4;
  localparam int FINAL_NUM = 9;

  localparam int MAX_MULT_DEF = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN  = 2'd1;

  typedef enum logic [2:0] {
    ST_FIT     = 3'd0,
    ST_SHORT   = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_AMBIG   = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

endpackage

/* rtl/core/cmc_prod.sv */
// Shared products: a = rate*length, count^2, a^2 and count*a over three stages.
module cmc_prod
  import cmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RATE_W-1:0] avg_rate,
  input  logic [LEN_W-1:0]  min_len,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              node_valid,
  input  logic [LEN_W-1:0]  node_length,
  input  logic [CNT_W-1:0]  start_count,
  output logic              out_valid,
  input  logic              out_ready,
  output status_t           out_pre,
  output logic [A_W-1:0]    out_a,
  output logic [R_W-1:0]    out_r,
  output logic [P_W-1:0]    out_p,
  output logic [Q_W-1:0]    out_q
);

  logic rdy1, rdy2, rdy3;

  logic             v1_r, v2_r, v3_r;
  status_t          pre1_r, pre2_r, pre3_r;
  status_t          pre1_nxt;
  logic [A_W-1:0]   a1_r, a2_r, a3_r;
  logic [R_W-1:0]   r1_r, r2_r, r3_r;
  logic [CNT_W-1:0] c1_r;
  logic [2*AL_W-1:0]    pll_r;
  logic [AL_W+AH_W-1:0] plh_r;
  logic [2*AH_W-1:0]    phh_r;
  logic [CNT_W+AL_W-1:0] qcl_r;
  logic [CNT_W+AH_W-1:0] qch_r;
  logic [P_W-1:0]   p3_r;
  logic [Q_W-1:0]   q3_r;

  // Stage advance chain
  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Early classification of the node
  always_comb begin
    if (!node_valid || avg_rate == '0) begin
      pre1_nxt = ST_INVALID;
    end else if (node_length < min_len || start_count == '0) begin
      pre1_nxt = ST_SHORT;
    end else begin
      pre1_nxt = ST_FIT;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage 1: a and count squared
  always_ff @(posedge clk) begin
    if (rdy1) begin
      pre1_r <= pre1_nxt;
      a1_r   <= A_W'(avg_rate) * A_W'(node_length);
      r1_r   <= R_W'(start_count) * R_W'(start_count);
      c1_r   <= start_count;
    end
  end

  // Stage 2: partial products of a^2 and count*a
  always_ff @(posedge clk) begin
    if (rdy2) begin
      pre2_r <= pre1_r;
      a2_r   <= a1_r;
      r2_r   <= r1_r;
      pll_r  <= (2*AL_W)'(a1_r[AL_W-1:0]) * (2*AL_W)'(a1_r[AL_W-1:0]);
      plh_r  <= (AL_W+AH_W)'(a1_r[AL_W-1:0]) * (AL_W+AH_W)'(a1_r[A_W-1:AL_W]);
      phh_r  <= (2*AH_W)'(a1_r[A_W-1:AL_W]) * (2*AH_W)'(a1_r[A_W-1:AL_W]);
      qcl_r  <= (CNT_W+AL_W)'(c1_r) * (CNT_W+AL_W)'(a1_r[AL_W-1:0]);
      qch_r  <= (CNT_W+AH_W)'(c1_r) * (CNT_W+AH_W)'(a1_r[A_W-1:AL_W]);
    end
  end

  // Stage 3: sum the partials
  always_ff @(posedge clk) begin
    if (rdy3) begin
      pre3_r <= pre2_r;
      a3_r   <= a2_r;
      r3_r   <= r2_r;
      p3_r   <= P_W'(pll_r) + (P_W'(plh_r) << (AL_W + 1)) + (P_W'(phh_r) << (2*AL_W));
      q3_r   <= Q_W'(qcl_r) + (Q_W'(qch_r) << AL_W);
    end
  end

  assign out_valid = v3_r;
  assign out_pre   = pre3_r;
  assign out_a     = a3_r;
  assign out_r     = r3_r;
  assign out_p     = p3_r;
  assign out_q     = q3_r;

endmodule

/* rtl/core/cmc_lanes.sv */
// One lane per candidate copy number: squared deviation and threshold tests.
module cmc_lanes
  import cmc_pkg::*;
#(
  parameter int MAX_MULT = MAX_MULT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  status_t             in_pre,
  input  logic [A_W-1:0]      in_a,
  input  logic [R_W-1:0]      in_r,
  input  logic [P_W-1:0]      in_p,
  input  logic [Q_W-1:0]      in_q,
  output logic                out_valid,
  input  logic                out_ready,
  output status_t             out_pre,
  output logic [MAX_MULT-1:0] out_keep,
  output logic [MAX_MULT-1:0] out_final,
  output logic [MAX_MULT-1:0] out_amb
);

  logic rdy4, rdy5;
  logic v4_r, v5_r;
  status_t pre4_r, pre5_r;

  logic [SQ_W-1:0]     d2_r [MAX_MULT];   // (T - E)^2
  logic [SQ_W-1:0]     w_r  [MAX_MULT];   // E * 2^24
  logic [MAX_MULT-1:0] amb4_r, amb5_r, keep5_r, final5_r;

  logic [SQ_W-1:0] t2;
  assign t2 = SQ_W'(in_r) << (2*FRAC_W);

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign in_ready = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) pre4_r <= in_pre;
    if (rdy5) pre5_r <= pre4_r;
  end

  for (genvar k = 0; k < MAX_MULT; k++) begin : g_lane
    localparam int I = k + 1;

    // Stage 4: D^2 = T^2 - 2iQ*2^24 + i^2 P, E scaled, neighbor comparison
    always_ff @(posedge clk) begin
      if (rdy4) begin
        d2_r[k] <= t2 + SQ_W'(I*I) * SQ_W'(in_p)
                   - ((SQ_W'(2*I) * SQ_W'(in_q)) << FRAC_W);
        w_r[k]  <= (SQ_W'(I) * SQ_W'(in_a)) << FRAC_W;
        if (k < MAX_MULT - 1) begin
          amb4_r[k] <= t2 > SQ_W'(I*(I+1)) * SQ_W'(in_p);
        end else begin
          amb4_r[k] <= 1'b0;
        end
      end
    end

    // Stage 5: threshold tests
    always_ff @(posedge clk) begin
      if (rdy5) begin
        keep5_r[k]  <= SQ_W'(KEEP_DEN) * d2_r[k] < SQ_W'(KEEP_NUM) * w_r[k];
        final5_r[k] <= d2_r[k] < SQ_W'(FINAL_NUM) * w_r[k];
        amb5_r[k]   <= amb4_r[k];
      end
    end
  end

  assign out_valid = v5_r;
  assign out_pre   = pre5_r;
  assign out_keep  = keep5_r;
  assign out_final = final5_r;
  assign out_amb   = amb5_r;

endmodule

/* rtl/core/cmc_pick.sv */
// Picks the first kept candidate and registers the result transaction.
module cmc_pick
  import cmc_pkg::*;
#(
  parameter int MAX_MULT = MAX_MULT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  status_t             in_pre,
  input  logic [MAX_MULT-1:0] in_keep,
  input  logic [MAX_MULT-1:0] in_final,
  input  logic [MAX_MULT-1:0] in_amb,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MULT_W-1:0]   out_mult,
  output status_t             out_status
);

  localparam int IDX_W = $clog2(MAX_MULT + 1);

  logic              v_r;
  logic [MULT_W-1:0] mult_r, mult_nxt;
  status_t           st_r, st_nxt;
  logic [IDX_W-1:0]  sel;
  logic              found, amb_sel, fin_sel;

  assign in_ready = !v_r || out_ready;

  // First lane whose score beats the starting bound
  always_comb begin
    sel     = '0;
    found   = 1'b0;
    amb_sel = 1'b0;
    fin_sel = 1'b0;
    for (int k = MAX_MULT - 1; k >= 0; k--) begin
      if (in_keep[k]) begin
        sel     = IDX_W'(k + 1);
        found   = 1'b1;
        amb_sel = in_amb[k];
        fin_sel = in_final[k];
      end
    end
  end

  // Result code; copy numbers above 15 wrap to the field width
  always_comb begin
    mult_nxt = '0;
    if (in_pre != ST_FIT) begin
      st_nxt = in_pre;
    end else if (!found) begin
      st_nxt = ST_NOFIT;
    end else if (amb_sel) begin
      st_nxt = ST_AMBIG;
    end else if (fin_sel) begin
      st_nxt   = ST_FIT;
      mult_nxt = MULT_W'(sel);
    end else begin
      st_nxt = ST_NOFIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      mult_r <= mult_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_valid  = v_r;
  assign out_mult   = mult_r;
  assign out_status = st_r;

endmodule

/* rtl/core/coverage_multiplicity_classifier.sv */
// Top level of the coverage multiplicity classifier.
// Takes one node per transaction and returns one copy-number estimate per node,
// in order. The pipeline takes a new node every cycle while the output side is
// not stalling and holds six register stages; the depth is set by the split of
// the 56x56-bit square and the per-candidate deviation and threshold stages.
// Scores of all candidates are evaluated in parallel lanes and compared
// exactly. The configuration registers are written through the cfg port,
// which is always ready; write them only while no node is in flight.
module coverage_multiplicity_classifier
  import cmc_pkg::*;
#(
  parameter int MAX_MULTIPLICITY = MAX_MULT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input: tdata = node_length[23:0], start_count[47:24]
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          in_tdata,
  // input: tuser = node_valid
  input  logic                 in_tuser,
  // output: tdata = multiplicity[3:0], status[6:4], zero pad[7]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [RATE_W-1:0] avg_rate_r;
  logic [LEN_W-1:0]  min_len_r;

  logic            pv, pr;
  status_t         p_pre;
  logic [A_W-1:0]  p_a;
  logic [R_W-1:0]  p_r;
  logic [P_W-1:0]  p_p;
  logic [Q_W-1:0]  p_q;

  logic                        lv, lr;
  status_t                     l_pre;
  logic [MAX_MULTIPLICITY-1:0] l_keep, l_final, l_amb;

  logic [MULT_W-1:0] res_mult;
  status_t           res_status;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_rate_r <= '0;
      min_len_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AVG_RATE: avg_rate_r <= cfg_data;
        CFG_MIN_LEN:  min_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  cmc_prod u_prod (
    .clk         (clk),
    .rst_n       (rst_n),
    .avg_rate    (avg_rate_r),
    .min_len     (min_len_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .node_valid  (in_tuser),
    .node_length (in_tdata[LEN_W-1:0]),
    .start_count (in_tdata[LEN_W+CNT_W-1:LEN_W]),
    .out_valid   (pv),
    .out_ready   (pr),
    .out_pre     (p_pre),
    .out_a       (p_a),
    .out_r       (p_r),
    .out_p       (p_p),
    .out_q       (p_q)
  );

  cmc_lanes #(.MAX_MULT(MAX_MULTIPLICITY)) u_lanes (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pv),
    .in_ready  (pr),
    .in_pre    (p_pre),
    .in_a      (p_a),
    .in_r      (p_r),
    .in_p      (p_p),
    .in_q      (p_q),
    .out_valid (lv),
    .out_ready (lr),
    .out_pre   (l_pre),
    .out_keep  (l_keep),
    .out_final (l_final),
    .out_amb   (l_amb)
  );

  cmc_pick #(.MAX_MULT(MAX_MULTIPLICITY)) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (lv),
    .in_ready   (lr),
    .in_pre     (l_pre),
    .in_keep    (l_keep),
    .in_final   (l_final),
    .in_amb     (l_amb),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_mult   (res_mult),
    .out_status (res_status)
  );

  assign out_tdata = {1'b0, res_status, res_mult};

endmodule
